// File: sv/stp_pkg.sv
// Package of the section time profiler: operation codes, state types and
// the command and status records between controller and datapath.
// No dependencies.
`default_nettype none
package stp_pkg;

   localparam int DEF_MAX_SECTIONS = 16;
   localparam int DEF_TIME_BITS    = 32;
   localparam int SHARE_SCALE      = 10000;

   typedef enum logic [2:0] {
      OP_SEC_START   = 3'd0,
      OP_SEC_END     = 3'd1,
      OP_FRAME_START = 3'd2,
      OP_FRAME_END   = 3'd3,
      OP_READ_FRAME  = 3'd4,
      OP_READ_RUN    = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_END_WR,
      ST_SWEEP,
      ST_FE_RD,
      ST_FE_START,
      ST_FE_WAIT,
      ST_FE_AFT,
      ST_RD_OUT,
      ST_RUN_WAIT,
      ST_RESP
   } ctrl_state_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_CHECK,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic capture;
      logic addr_clear;
      logic addr_inc;
      logic wr_start;
      logic wr_end;
      logic clr_frame;
      logic clr_all;
      logic wr_share;
      logic load_fbegin;
      logic load_len;
      logic add_aft;
      logic div_start;
      logic div_run;
      logic res_frame;
      logic res_run;
      logic res_none;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       known;
      logic       aft_zero;
      logic       used_zero;
      logic       addr_last_used;
      logic       addr_last_max;
      logic       div_done;
   } status_type;

endpackage
`default_nettype wire

// File: sv/stp_share_div.sv
// Share unit: floor(part * 10000 / whole), saturated at 65535. Uses stp_pkg.
// One multiply, a saturation check, then 16 restoring steps if not saturated.
`default_nettype none
module stp_share_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] part,
   input  wire logic [31:0] whole,
   output logic             done,
   output logic [15:0]      share
);
   import stp_pkg::*;

   localparam logic [13:0] SCALE = 14'(SHARE_SCALE);

   div_state_type state_ff, state_in;
   logic [31:0] part_ff, whole_ff;
   logic [47:0] rem_ff, rem_in, dv_ff, dv_in;
   logic [15:0] quot_ff, quot_in;
   logic [3:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == DIV_IDLE) begin
         part_ff  <= part;
         whole_ff <= whole;
      end
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               state_in = DIV_MUL;
            end
         end
         DIV_MUL: begin
            rem_in   = 48'(part_ff) * 48'(SCALE);
            state_in = DIV_CHECK;
         end
         DIV_CHECK: begin
            if (rem_ff >= {whole_ff, 16'd0}) begin
               quot_in  = 16'hFFFF;
               state_in = DIV_DONE;
            end else begin
               dv_in    = {1'b0, whole_ff, 15'd0};
               quot_in  = 16'd0;
               cnt_in   = 4'd15;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (rem_ff >= dv_ff) begin
               rem_in  = rem_ff - dv_ff;
               quot_in = {quot_ff[14:0], 1'b1};
            end else begin
               quot_in = {quot_ff[14:0], 1'b0};
            end
            dv_in  = dv_ff >> 1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            done     = 1'b1;
            state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   assign share = quot_ff;

endmodule
`default_nettype wire

// File: sv/stp_datapath.sv
// Datapath of the section time profiler: item registers, section tables,
// frame and run totals, result register. Uses stp_pkg and stp_share_div.
`default_nettype none
module stp_datapath #(
   parameter int MAX_SECTIONS = stp_pkg::DEF_MAX_SECTIONS,
   parameter int TIME_BITS    = stp_pkg::DEF_TIME_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stp_pkg::cmd_type    cmd,
   output stp_pkg::status_type      status,
   input  wire logic                csr_write_enable,
   input  wire logic [4:0]          csr_write_data,
   input  wire logic [2:0]          req_operation,
   input  wire logic [3:0]          req_section_index,
   input  wire logic [31:0]         req_now_ms,
   output logic                     rsp_valid_res,
   output logic [3:0]               rsp_section_id,
   output logic [31:0]              rsp_tick_total,
   output logic [31:0]              rsp_raw_ms_total,
   output logic [31:0]              rsp_call_count,
   output logic [15:0]              rsp_percent_hundredths
);
   import stp_pkg::*;

   localparam int IDXW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int TW   = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam logic [32:0] ONE33 = 33'd1;
   localparam logic [31:0] TIME_MASK = 32'((ONE33 << TW) - ONE33);
   localparam logic [8:0]  MAX9 = 9'(MAX_SECTIONS);
   localparam logic [IDXW-1:0] LAST_ADDR = IDXW'(MAX_SECTIONS - 1);

   logic [4:0]      cfg_ff;
   logic [2:0]      op_ff;
   logic [3:0]      idx_ff;
   logic [31:0]     now_ff;
   logic [IDXW-1:0] addr_ff;
   logic [31:0]     fbegin_ff, aft_ff, len_ff;

   logic [31:0] start_mem [MAX_SECTIONS];
   logic [31:0] fticks_mem [MAX_SECTIONS];
   logic [31:0] fraw_mem [MAX_SECTIONS];
   logic [31:0] fcalls_mem [MAX_SECTIONS];
   logic [31:0] rticks_mem [MAX_SECTIONS];
   logic [31:0] rraw_mem [MAX_SECTIONS];
   logic [31:0] rcalls_mem [MAX_SECTIONS];
   logic [15:0] share_mem [MAX_SECTIONS];

   logic [31:0] start_q, fticks_q, fraw_q, fcalls_q, rticks_q, rraw_q, rcalls_q;
   logic [15:0] share_q;

   logic [8:0]  used, idx9, addr9;
   logic [7:0]  idx8;
   logic [31:0] d_raw, d_clamp, len_raw, len_clamp;
   logic        clr_f;
   logic        div_done;
   logic [15:0] div_share;

   assign used  = ({4'd0, cfg_ff} > MAX9) ? MAX9 : {4'd0, cfg_ff};
   assign idx9  = {5'd0, idx_ff};
   assign idx8  = {4'd0, req_section_index};
   assign addr9 = 9'(addr_ff);
   assign d_raw     = (now_ff - start_q) & TIME_MASK;
   assign d_clamp   = (d_raw == 32'd0) ? 32'd1 : d_raw;
   assign len_raw   = (now_ff - fbegin_ff) & TIME_MASK;
   assign len_clamp = (len_raw == 32'd0) ? 32'd1 : len_raw;
   assign clr_f     = cmd.clr_frame | cmd.clr_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= 5'd0;
         addr_ff   <= '0;
         fbegin_ff <= 32'd0;
         aft_ff    <= 32'd0;
      end else begin
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
         if (cmd.capture) begin
            addr_ff <= idx8[IDXW-1:0];
         end else if (cmd.addr_clear) begin
            addr_ff <= '0;
         end else if (cmd.addr_inc) begin
            addr_ff <= addr_ff + IDXW'(1);
         end
         if (cmd.load_fbegin) begin
            fbegin_ff <= now_ff;
         end
         if (cmd.add_aft) begin
            aft_ff <= aft_ff + len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         idx_ff <= req_section_index;
         now_ff <= req_now_ms & TIME_MASK;
      end
      if (cmd.load_len) begin
         len_ff <= len_clamp;
      end
   end

   always_ff @(posedge clock) begin
      start_q  <= start_mem[addr_ff];
      fticks_q <= fticks_mem[addr_ff];
      fraw_q   <= fraw_mem[addr_ff];
      fcalls_q <= fcalls_mem[addr_ff];
      rticks_q <= rticks_mem[addr_ff];
      rraw_q   <= rraw_mem[addr_ff];
      rcalls_q <= rcalls_mem[addr_ff];
      share_q  <= share_mem[addr_ff];
      if (cmd.clr_all || cmd.wr_start) begin
         start_mem[addr_ff] <= cmd.clr_all ? 32'd0 : now_ff;
      end
      if (clr_f || cmd.wr_end) begin
         fticks_mem[addr_ff] <= clr_f ? 32'd0 : fticks_q + d_clamp;
         fraw_mem[addr_ff]   <= clr_f ? 32'd0 : fraw_q + d_raw;
         fcalls_mem[addr_ff] <= clr_f ? 32'd0 : fcalls_q + 32'd1;
      end
      if (cmd.clr_all || cmd.wr_end) begin
         rticks_mem[addr_ff] <= cmd.clr_all ? 32'd0 : rticks_q + d_clamp;
         rraw_mem[addr_ff]   <= cmd.clr_all ? 32'd0 : rraw_q + d_raw;
         rcalls_mem[addr_ff] <= cmd.clr_all ? 32'd0 : rcalls_q + 32'd1;
      end
      if (clr_f || cmd.wr_share) begin
         share_mem[addr_ff] <= clr_f ? 16'd0 : div_share;
      end
   end

   stp_share_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .part  (cmd.div_run ? rticks_q : fticks_q),
      .whole (cmd.div_run ? aft_ff : len_ff),
      .done  (div_done),
      .share (div_share)
   );

   always_ff @(posedge clock) begin
      if (cmd.res_none) begin
         rsp_valid_res          <= 1'b0;
         rsp_section_id         <= 4'd0;
         rsp_tick_total         <= 32'd0;
         rsp_raw_ms_total       <= 32'd0;
         rsp_call_count         <= 32'd0;
         rsp_percent_hundredths <= 16'd0;
      end else if (cmd.res_frame) begin
         rsp_valid_res          <= 1'b1;
         rsp_section_id         <= idx_ff;
         rsp_tick_total         <= fticks_q;
         rsp_raw_ms_total       <= fraw_q;
         rsp_call_count         <= fcalls_q;
         rsp_percent_hundredths <= share_q;
      end else if (cmd.res_run) begin
         rsp_valid_res          <= 1'b1;
         rsp_section_id         <= idx_ff;
         rsp_tick_total         <= rticks_q;
         rsp_raw_ms_total       <= rraw_q;
         rsp_call_count         <= rcalls_q;
         rsp_percent_hundredths <= div_share;
      end
   end

   always_comb begin
      status.op             = op_ff;
      status.known          = idx9 < used;
      status.aft_zero       = aft_ff == 32'd0;
      status.used_zero      = used == 9'd0;
      status.addr_last_used = addr9 == (used - 9'd1);
      status.addr_last_max  = addr_ff == LAST_ADDR;
      status.div_done       = div_done;
   end

endmodule
`default_nettype wire

// File: sv/stp_ctrl.sv
// Controller of the section time profiler: sequences one item at a time
// over the datapath. Uses stp_pkg.
`default_nettype none
module stp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output stp_pkg::cmd_type         cmd,
   input  wire stp_pkg::status_type status
);
   import stp_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_all = 1'b1;
            if (status.addr_last_max) begin
               state_in = ST_IDLE;
            end else begin
               cmd.addr_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            unique case (status.op)
               OP_SEC_START: begin
                  cmd.res_none = 1'b1;
                  cmd.wr_start = status.known;
               end
               OP_SEC_END: begin
                  cmd.res_none = 1'b1;
                  if (status.known) begin
                     state_in = ST_END_WR;
                  end
               end
               OP_FRAME_START: begin
                  cmd.res_none    = 1'b1;
                  cmd.load_fbegin = 1'b1;
                  cmd.addr_clear  = 1'b1;
                  state_in        = ST_SWEEP;
               end
               OP_FRAME_END: begin
                  cmd.res_none   = 1'b1;
                  cmd.load_len   = 1'b1;
                  cmd.addr_clear = 1'b1;
                  state_in       = status.used_zero ? ST_FE_AFT : ST_FE_RD;
               end
               OP_READ_FRAME, OP_READ_RUN: begin
                  state_in = ST_RD_OUT;
               end
               default: begin
                  cmd.res_none = 1'b1;
               end
            endcase
         end
         ST_END_WR: begin
            cmd.wr_end = 1'b1;
            state_in   = ST_RESP;
         end
         ST_SWEEP: begin
            cmd.clr_frame = 1'b1;
            if (status.addr_last_max) begin
               state_in = ST_RESP;
            end else begin
               cmd.addr_inc = 1'b1;
            end
         end
         ST_FE_RD: begin
            state_in = ST_FE_START;
         end
         ST_FE_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_FE_WAIT;
         end
         ST_FE_WAIT: begin
            if (status.div_done) begin
               cmd.wr_share = 1'b1;
               if (status.addr_last_used) begin
                  state_in = ST_FE_AFT;
               end else begin
                  cmd.addr_inc = 1'b1;
                  state_in     = ST_FE_RD;
               end
            end
         end
         ST_FE_AFT: begin
            cmd.add_aft = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RD_OUT: begin
            state_in = ST_RESP;
            if (status.op == OP_READ_FRAME) begin
               cmd.res_frame = status.known;
               cmd.res_none  = !status.known;
            end else if (status.known && !status.aft_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_run   = 1'b1;
               state_in      = ST_RUN_WAIT;
            end else begin
               cmd.res_none = 1'b1;
            end
         end
         ST_RUN_WAIT: begin
            cmd.div_run = 1'b1;
            if (status.div_done) begin
               cmd.res_run = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: sv/section_time_profiler_core.sv
// Top level of the section time profiler: controller, datapath and share unit.
// Uses stp_pkg, stp_ctrl, stp_datapath.
//
// Use: software markers enter on the req_ channel (operation, section index,
// millisecond timestamp); every beat yields one beat on the rsp_ channel.
// Reads of a section in use set rsp_valid_res (a run read only once the run
// length is nonzero); all other beats carry every field zero.
// csr_write_enable/csr_write_data set the number of sections in use; write it
// only while the block is idle. One item is in flight at a time; req_stall
// is high from acceptance until its result beat is taken.
// Work per item: a section start is decoded and answered; a section end and
// a frame read take one more state; a run read runs the share unit (multiply,
// check, 16 steps; only multiply and check when the share saturates); a frame
// start sweeps all table rows, one a cycle; a frame end runs the share unit
// once per section in use.
// Reset: a clearing pass over all MAX_SECTIONS table rows zeroes the tables;
// no item is accepted during it. When the receiver stalls, the result beat
// holds in the output register and no new item is accepted.
`default_nettype none
module section_time_profiler_core #(
   parameter int MAX_SECTIONS = stp_pkg::DEF_MAX_SECTIONS,
   parameter int TIME_BITS    = stp_pkg::DEF_TIME_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [4:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_operation,
   input  wire logic [3:0]  req_section_index,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_valid_res,
   output logic [3:0]       rsp_section_id,
   output logic [31:0]      rsp_tick_total,
   output logic [31:0]      rsp_raw_ms_total,
   output logic [31:0]      rsp_call_count,
   output logic [15:0]      rsp_percent_hundredths
);
   import stp_pkg::*;

   cmd_type    cmd;
   status_type status;

   stp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   stp_datapath #(
      .MAX_SECTIONS (MAX_SECTIONS),
      .TIME_BITS    (TIME_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .req_operation          (req_operation),
      .req_section_index      (req_section_index),
      .req_now_ms             (req_now_ms),
      .rsp_valid_res          (rsp_valid_res),
      .rsp_section_id         (rsp_section_id),
      .rsp_tick_total         (rsp_tick_total),
      .rsp_raw_ms_total       (rsp_raw_ms_total),
      .rsp_call_count         (rsp_call_count),
      .rsp_percent_hundredths (rsp_percent_hundredths)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input open while a result is pending");

   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in flight");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_tick_total == 32'd0 &&
      rsp_raw_ms_total == 32'd0 && rsp_call_count == 32'd0 &&
      rsp_percent_hundredths == 16'd0 && rsp_section_id == 4'd0))
      else $error("invalid result carries data");

endmodule
`default_nettype wire

// File: tb/tb_section_time_profiler_core.sv
// Testbench for section_time_profiler_core: drives timing markers and reads,
// predicts every result beat and checks it field by field. Uses stp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_section_time_profiler_core;
   import stp_pkg::*;

   localparam int NSEC = 16;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic        valid_res;
      logic [3:0]  section_id;
      logic [31:0] tick_total;
      logic [31:0] raw_ms_total;
      logic [31:0] call_count;
      logic [15:0] percent_hundredths;
   } stats_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [4:0]  csr_write_data = 0;
   logic        req_valid = 0;
   wire         req_stall;
   logic [2:0]  req_operation = 0;
   logic [3:0]  req_section_index = 0;
   logic [31:0] req_now_ms = 0;
   wire         rsp_valid;
   logic        rsp_stall = 0;
   wire         rsp_valid_res;
   wire [3:0]   rsp_section_id;
   wire [31:0]  rsp_tick_total, rsp_raw_ms_total, rsp_call_count;
   wire [15:0]  rsp_percent_hundredths;

   section_time_profiler_core dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_section_index(req_section_index),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_valid_res(rsp_valid_res), .rsp_section_id(rsp_section_id),
      .rsp_tick_total(rsp_tick_total), .rsp_raw_ms_total(rsp_raw_ms_total),
      .rsp_call_count(rsp_call_count),
      .rsp_percent_hundredths(rsp_percent_hundredths)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [4:0]  sec_used;
   logic [31:0] t_start[NSEC], f_ticks[NSEC], f_raw[NSEC], r_ticks[NSEC];
   logic [31:0] r_raw[NSEC], f_calls[NSEC], r_calls[NSEC];
   logic [15:0] f_share[NSEC];
   logic [31:0] fr_begin, run_len;

   stats_type expected_stats[$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_rsp = 0;
   logic [31:0] ts = 0;

   function automatic logic [15:0] share_calc(logic [31:0] part, logic [31:0] whole);
      logic [63:0] q;
      if (whole == 0) return 16'd0;
      q = (64'(part) * 64'd10000) / 64'(whole);
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   task automatic model_reset();
      sec_used = 0;
      fr_begin = 0;
      run_len = 0;
      for (int i = 0; i < NSEC; i++) begin
         t_start[i] = 0; f_ticks[i] = 0; f_raw[i] = 0; r_ticks[i] = 0;
         r_raw[i] = 0; f_calls[i] = 0; r_calls[i] = 0; f_share[i] = 0;
      end
   endtask

   task automatic predict_stats(logic [2:0] op, logic [3:0] idx, logic [31:0] now);
      stats_type s;
      int used;
      logic [31:0] d, len;
      bit known;
      s = '0;
      used = (sec_used > NSEC) ? NSEC : sec_used;
      known = idx < used;
      case (op)
         OP_SEC_START: if (known) t_start[idx] = now;
         OP_SEC_END: if (known) begin
            d = now - t_start[idx];
            f_calls[idx]++; r_calls[idx]++;
            f_raw[idx] += d; r_raw[idx] += d;
            if (d == 0) d = 1;
            f_ticks[idx] += d; r_ticks[idx] += d;
         end
         OP_FRAME_START: begin
            fr_begin = now;
            for (int i = 0; i < NSEC; i++) begin
               f_ticks[i] = 0; f_raw[i] = 0; f_calls[i] = 0; f_share[i] = 0;
            end
         end
         OP_FRAME_END: begin
            len = now - fr_begin;
            if (len == 0) len = 1;
            for (int i = 0; i < used; i++) f_share[i] = share_calc(f_ticks[i], len);
            run_len += len;
         end
         OP_READ_FRAME: if (known)
            s = '{1'b1, idx, f_ticks[idx], f_raw[idx], f_calls[idx], f_share[idx]};
         OP_READ_RUN: if (known && run_len != 0)
            s = '{1'b1, idx, r_ticks[idx], r_raw[idx], r_calls[idx],
                  share_calc(r_ticks[idx], run_len)};
         default: ;
      endcase
      expected_stats = {expected_stats, s};
   endtask

   task automatic send_beat(logic [2:0] op, logic [3:0] idx, logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1;
      req_operation <= op;
      req_section_index <= idx;
      req_now_ms <= now;
      predict_stats(op, idx, now);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      req_valid <= 0;
      @(posedge clock);
   endtask

   // hold the output stall at random, or fully during a hold-off
   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      stats_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_valid_res, rsp_section_id, rsp_tick_total, rsp_raw_ms_total,
                 rsp_call_count, rsp_percent_hundredths};
         if (expected_stats.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            want = expected_stats.pop_front();
            beats_checked++;
            if (got.valid_res !== want.valid_res) begin
               $error("valid_res exp %0h got %0h", want.valid_res, got.valid_res); errors++;
            end
            if (got.section_id !== want.section_id) begin
               $error("section_id exp %0h got %0h", want.section_id, got.section_id);
               errors++;
            end
            if (got.tick_total !== want.tick_total) begin
               $error("tick_total exp %0h got %0h", want.tick_total, got.tick_total);
               errors++;
            end
            if (got.raw_ms_total !== want.raw_ms_total) begin
               $error("raw_ms_total exp %0h got %0h", want.raw_ms_total, got.raw_ms_total);
               errors++;
            end
            if (got.call_count !== want.call_count) begin
               $error("call_count exp %0h got %0h", want.call_count, got.call_count);
               errors++;
            end
            if (got.percent_hundredths !== want.percent_hundredths) begin
               $error("percent_hundredths exp %0h got %0h", want.percent_hundredths,
                      got.percent_hundredths);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_sections(logic [4:0] n);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= n;
      @(posedge clock);
      csr_write_enable <= 0;
      sec_used = n;
   endtask

   task automatic test_directed();
      write_sections(5'd3);
      send_beat(OP_READ_RUN, 4'd0, 32'd0);
      send_beat(OP_SEC_END, 4'd1, 32'd7);
      send_beat(OP_SEC_START, 4'd0, 32'hFFFF_FFF0);
      send_beat(OP_SEC_END, 4'd0, 32'h0000_0010);
      send_beat(OP_SEC_START, 4'd2, 32'd100);
      send_beat(OP_SEC_END, 4'd2, 32'd100);
      send_beat(OP_SEC_START, 4'd15, 32'd5);
      send_beat(OP_SEC_END, 4'd3, 32'd9);
      send_beat(OP_FRAME_END, 4'd0, 32'd0);
      send_beat(OP_READ_FRAME, 4'd0, 32'd0);
      send_beat(OP_READ_FRAME, 4'd2, 32'd0);
      send_beat(OP_READ_FRAME, 4'd15, 32'd0);
      send_beat(OP_READ_RUN, 4'd0, 32'd0);
      send_beat(OP_READ_RUN, 4'd1, 32'd0);
      send_beat(OP_SPARE_A, 4'd0, 32'hFFFF_FFFF);
      send_beat(OP_SPARE_B, 4'd15, 32'd0);
      send_beat(OP_FRAME_START, 4'd0, 32'hFFFF_FFFF);
      send_beat(OP_READ_FRAME, 4'd0, 32'd0);
      send_beat(OP_FRAME_END, 4'd0, 32'd1000);
      send_beat(OP_READ_RUN, 4'd0, 32'd0);
      write_sections(5'd31);
      send_beat(OP_SEC_START, 4'd15, 32'd0);
      send_beat(OP_SEC_END, 4'd15, 32'hFFFF_FFFF);
      send_beat(OP_FRAME_END, 4'd0, 32'd1001);
      send_beat(OP_READ_FRAME, 4'd15, 32'd0);
      send_beat(OP_READ_RUN, 4'd15, 32'd0);
   endtask

   task automatic random_frame(int used);
      int n;
      logic [3:0] idx;
      n = $urandom_range(12, 2);
      ts = ($urandom_range(9) == 0) ? $urandom : ts + $urandom_range(20);
      send_beat(OP_FRAME_START, 4'($urandom), ts);
      for (int k = 0; k < n; k++) begin
         idx = (used > 0 && $urandom_range(9) != 0) ? 4'($urandom_range(used - 1))
                                                    : 4'($urandom);
         send_beat(OP_SEC_START, idx, ts);
         ts += $urandom_range(3) == 0 ? 0 : $urandom_range(50);
         send_beat(OP_SEC_END, idx, ($urandom_range(19) == 0) ? $urandom : ts);
      end
      ts += $urandom_range(($urandom_range(7) == 0) ? 0 : 200);
      if ($urandom_range(5) != 0) send_beat(OP_FRAME_END, 4'($urandom), ts);
      send_beat(OP_READ_FRAME, 4'($urandom), $urandom);
      send_beat(OP_READ_RUN, 4'($urandom), $urandom);
      if ($urandom_range(3) == 0) send_beat(3'($urandom), 4'($urandom), $urandom);
   endtask

   task automatic test_random_phase(int idle, int stl, int target);
      int used;
      send_idle_pct = idle;
      stall_pct = stl;
      used = $urandom_range(16, 1);
      write_sections(5'(used));
      while (beats_sent < target) random_frame(used);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         repeat (10) send_beat(OP_READ_FRAME, 4'($urandom), $urandom);
      join
   endtask

   initial begin
      model_reset();
      repeat (2) @(posedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_random_phase(0, 0, 350);
      test_random_phase(85, 0, 650);
      test_random_phase(0, 85, 950);
      test_random_phase(28, 28, 1250);
      write_sections(5'd0);
      test_random_phase(0, 0, 1300);
      write_sections(5'd16);
      test_random_phase(28, 28, 1420);
      send_idle_pct = 0;
      stall_pct = 0;
      drain();
      $display("Sent %0d beats over six idle/stall phases and section counts 0..31;",
               beats_sent);
      $display("checked %0d result beats against the predictor.", beats_checked);
      if (errors == 0 && expected_stats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #150ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
sv/stp_pkg.sv
sv/stp_share_div.sv
sv/stp_datapath.sv
sv/stp_ctrl.sv
sv/section_time_profiler_core.sv
tb/tb_section_time_profiler_core.sv
